FILE: sv/odo_pkg.sv
package odo_pkg;

   typedef struct packed {
      logic signed [31:0] right_count;
      logic signed [31:0] left_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] x_position;
      logic signed [31:0] y_position;
      logic signed [31:0] heading;
      logic signed [31:0] linear_speed;
      logic signed [31:0] angular_speed;
   } rsp_type;

   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_DISTANCE    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_INV_TRACK   = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_SAMPLE_RATE = 2'd2;

   localparam logic [31:0] DISTANCE_RESET    = 32'd69579;
   localparam logic [31:0] INV_TRACK_RESET   = 32'd59662933;
   localparam logic [15:0] SAMPLE_RATE_RESET = 16'd250;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 68;
   localparam int REM_BITS = 49;

   localparam logic signed [33:0] PI_Q29       = 34'sd1686629713;
   localparam logic signed [33:0] TWO_PI_Q29   = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30  = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic [31:0]        TWO_PI_DIV   = 32'd3373259426;
   // A little below 2^63 / TWO_PI_DIV, so the quotient estimate is never too large.
   localparam logic [31:0]        TWO_PI_RECIP = 32'd2734261000;
   localparam int ATAN_IW = 5;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_DR, S_MUL_DL, S_CAP_DL, S_MUL_DH, S_MUL_LIN, S_MUL_ANG_LO,
      S_MUL_ANG_HI, S_CAP_ANG, S_WAIT, S_MUL_X, S_MUL_Y, S_CAP_Y, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_DR, MUL_DL, MUL_DH, MUL_LIN, MUL_ANG_LO, MUL_ANG_HI, MUL_X, MUL_Y
   } mul_sel_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_DR, CAP_DL, CAP_DH, CAP_LIN, CAP_ANG_LO, CAP_ANG_HI, CAP_X, CAP_Y
   } cap_type;

   typedef struct packed {
      logic        capture_in;
      mul_sel_type mul_sel;
      cap_type     cap;
      logic        start_rem;
      logic        load;
   } cmd_type;

   typedef struct packed {
      logic units_done;
      logic out_free;
   } status_type;

   function automatic logic [31:0] atan_q30(input logic [ATAN_IW-1:0] i);
      case (i)
         5'd0:  atan_q30 = 32'd843314856;
         5'd1:  atan_q30 = 32'd497837829;
         5'd2:  atan_q30 = 32'd263043836;
         5'd3:  atan_q30 = 32'd133525158;
         5'd4:  atan_q30 = 32'd67021686;
         5'd5:  atan_q30 = 32'd33543515;
         5'd6:  atan_q30 = 32'd16775850;
         5'd7:  atan_q30 = 32'd8388437;
         5'd8:  atan_q30 = 32'd4194282;
         5'd9:  atan_q30 = 32'd2097149;
         5'd10: atan_q30 = 32'd1048575;
         5'd11: atan_q30 = 32'd524287;
         5'd12: atan_q30 = 32'd262143;
         5'd13: atan_q30 = 32'd131071;
         5'd14: atan_q30 = 32'd65535;
         5'd15: atan_q30 = 32'd32767;
         5'd16: atan_q30 = 32'd16383;
         5'd17: atan_q30 = 32'd8191;
         5'd18: atan_q30 = 32'd4095;
         5'd19: atan_q30 = 32'd2047;
         5'd20: atan_q30 = 32'd1023;
         5'd21: atan_q30 = 32'd511;
         5'd22: atan_q30 = 32'd255;
         5'd23: atan_q30 = 32'd127;
         5'd24: atan_q30 = 32'd63;
         5'd25: atan_q30 = 32'd31;
         5'd26: atan_q30 = 32'd15;
         5'd27: atan_q30 = 32'd7;
         5'd28: atan_q30 = 32'd3;
         5'd29: atan_q30 = 32'd1;
         default: atan_q30 = 32'd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v > 68'sd2147483647) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (v < -68'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

FILE: sv/odo_cordic.sv
module odo_cordic
   import odo_pkg::*;
#(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] heading,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out,
   output logic               done
);

   localparam int IW = $clog2(CORDIC_STEPS + 1);

   logic              busy_ff, busy_in;
   logic [IW-1:0]     step_ff, step_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic              neg_ff, neg_in;
   logic signed [33:0] z0, dx, dy, ang;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      z0      = {{1{heading[31]}}, heading, 1'b0};
      dx      = y_ff >>> step_ff;
      dy      = x_ff >>> step_ff;
      ang     = {2'b00, atan_q30(ATAN_IW'(step_ff))};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = CORDIC_START;
         y_in    = '0;
         // Fold the angle into the right half plane; the results are negated later.
         if (z0 > HALF_PI_Q30) begin
            z_in   = z0 - PI_Q30;
            neg_in = 1'b1;
         end else if (z0 < -HALF_PI_Q30) begin
            z_in   = z0 + PI_Q30;
            neg_in = 1'b1;
         end else begin
            z_in   = z0;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;
   assign done    = !busy_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !done)
      else $error("rotation unit not busy after start");

endmodule

FILE: sv/odo_rem.sv
module odo_rem
   import odo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [49:0] dividend,
   output logic [31:0]        remainder,
   output logic               negative,
   output logic               done
);

   logic [2:0]          stage_ff, stage_in;
   logic [REM_BITS-1:0] mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [17:0]         quo_ff, quo_in;
   logic [REM_BITS-1:0] qd_ff, qd_in;
   logic [31:0]         rem_ff, rem_in;
   logic signed [49:0]  mag;
   logic [49:0]         est;
   logic [49:0]         qd_full;
   logic [33:0]         diff;

   // Three steps: estimate the quotient with a reciprocal, multiply it back,
   // then one compare and subtract, since the estimate is short by at most one.
   always_comb begin
      stage_in = {stage_ff[1:0], start};
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      qd_in    = qd_ff;
      rem_in   = rem_ff;
      mag      = dividend[49] ? -dividend : dividend;
      est      = mag_ff[REM_BITS-1:31] * TWO_PI_RECIP;
      qd_full  = quo_ff * TWO_PI_DIV;
      diff     = 34'(mag_ff - qd_ff);
      if (start) begin
         mag_in = mag[REM_BITS-1:0];
         neg_in = dividend[49];
      end
      if (stage_ff[0]) quo_in = est[49:32];
      if (stage_ff[1]) qd_in = qd_full[REM_BITS-1:0];
      if (stage_ff[2]) begin
         if (diff >= {2'b00, TWO_PI_DIV}) begin
            rem_in = 32'(diff - {2'b00, TWO_PI_DIV});
         end else begin
            rem_in = diff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;
   assign negative  = neg_ff;
   assign done      = !(|stage_ff);

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !done)
      else $error("remainder unit not busy after start");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      stage_ff[2] |=> (rem_ff < TWO_PI_DIV))
      else $error("remainder not below the divisor");

   a_one_stage: assert property (@(posedge clock) disable iff (reset)
      $onehot0(stage_ff))
      else $error("more than one remainder step active");

endmodule

FILE: sv/odo_dpath.sv
module odo_dpath
   import odo_pkg::*;
#(
   parameter int COUNT_WIDTH  = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   output rsp_type           rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              csr_write_enable,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [31:0]       csr_write_data,
   input  cmd_type           cmd,
   output status_type        status
);

   localparam int CW = COUNT_WIDTH;

   logic [31:0] dpc_ff, itw_ff;
   logic [15:0] sr_ff;
   logic [CW-1:0] last_r_ff, last_l_ff, d_r, d_l;
   logic signed [MUL_W-1:0] cr_ff, cl_ff, cr_in, cl_in;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff, ang_lo_ff, ang_full, pos_sum;
   logic signed [53:0] dr_ff, dl_ff;
   logic signed [54:0] s_sum, d_sum, m_half;
   logic signed [33:0] diff_c, s_c, m_c;
   logic signed [49:0] dh_ff;
   logic signed [41:0] dh_c;
   logic signed [31:0] lin_ff, ang_ff, pose_x_ff, pose_y_ff, pose_h_ff;
   logic signed [33:0] cos_v, sin_v, rem_s, h_sum, h_wrap;
   logic [31:0] rem_v;
   logic rem_neg, cordic_done, rem_done;
   rsp_type rsp_ff;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= DISTANCE_RESET;
         itw_ff <= INV_TRACK_RESET;
         sr_ff  <= SAMPLE_RATE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DISTANCE:    dpc_ff <= csr_write_data;
            CSR_INV_TRACK:   itw_ff <= csr_write_data;
            CSR_SAMPLE_RATE: sr_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      d_r   = req_data.right_count[CW-1:0] - last_r_ff;
      d_l   = req_data.left_count[CW-1:0] - last_l_ff;
      cr_in = {{(MUL_W-CW){d_r[CW-1]}}, d_r};
      cl_in = -{{(MUL_W-CW){d_l[CW-1]}}, d_l};
   end

   always_comb begin
      s_sum  = {dr_ff[53], dr_ff} + {dl_ff[53], dl_ff};
      d_sum  = {dr_ff[53], dr_ff} - {dl_ff[53], dl_ff};
      m_half = s_sum >>> 1;
      if (d_sum > 55'sd2147483648) diff_c = 34'sd2147483648;
      else if (d_sum < -55'sd2147483648) diff_c = -34'sd2147483648;
      else diff_c = d_sum[33:0];
      // Beyond 2^32 the speed saturates for any nonzero rate, so a tight clamp is exact.
      if (s_sum > 55'sd4294967296) s_c = 34'sd4294967296;
      else if (s_sum < -55'sd4294967296) s_c = -34'sd4294967296;
      else s_c = s_sum[33:0];
      if (m_half > 55'sd4294967296) m_c = 34'sd4294967296;
      else if (m_half < -55'sd4294967296) m_c = -34'sd4294967296;
      else m_c = m_half[33:0];
      if (dh_ff > 50'sd1099511627776) dh_c = 42'sd1099511627776;
      else if (dh_ff < -50'sd1099511627776) dh_c = -42'sd1099511627776;
      else dh_c = dh_ff[41:0];
   end

   // Shared multiplier; the angular speed product is formed from two halves.
   always_comb begin
      case (cmd.mul_sel)
         MUL_DR: begin
            mul_a = cr_ff;
            mul_b = {2'b00, dpc_ff};
         end
         MUL_DL: begin
            mul_a = cl_ff;
            mul_b = {2'b00, dpc_ff};
         end
         MUL_DH: begin
            mul_a = diff_c;
            mul_b = {2'b00, itw_ff};
         end
         MUL_LIN: begin
            mul_a = s_c;
            mul_b = {18'd0, sr_ff};
         end
         MUL_ANG_LO: begin
            mul_a = {13'd0, dh_c[20:0]};
            mul_b = {18'd0, sr_ff};
         end
         MUL_ANG_HI: begin
            mul_a = {{13{dh_c[41]}}, dh_c[41:21]};
            mul_b = {18'd0, sr_ff};
         end
         MUL_X: begin
            mul_a = m_c;
            mul_b = cos_v;
         end
         MUL_Y: begin
            mul_a = m_c;
            mul_b = sin_v;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      ang_full = (prod_ff <<< 21) + ang_lo_ff;
      pos_sum  = (cmd.cap == CAP_X) ? (PROD_W'(pose_x_ff) + (prod_ff >>> 30))
                                    : (PROD_W'(pose_y_ff) + (prod_ff >>> 30));
      rem_s    = rem_neg ? -{2'b00, rem_v} : {2'b00, rem_v};
      h_sum    = 34'(pose_h_ff) + rem_s;
      if (h_sum > PI_Q29) h_wrap = h_sum - TWO_PI_Q29;
      else if (h_sum < -PI_Q29) h_wrap = h_sum + TWO_PI_Q29;
      else h_wrap = h_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_r_ff <= '0;
         last_l_ff <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
      end else begin
         if (cmd.capture_in) begin
            last_r_ff <= req_data.right_count[CW-1:0];
            last_l_ff <= req_data.left_count[CW-1:0];
         end
         if (cmd.cap == CAP_X) pose_x_ff <= sat32(pos_sum);
         if (cmd.cap == CAP_Y) begin
            pose_y_ff <= sat32(pos_sum);
            pose_h_ff <= h_wrap[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.capture_in) begin
         cr_ff <= cr_in;
         cl_ff <= cl_in;
      end
      case (cmd.cap)
         CAP_DR:     dr_ff     <= prod_ff[65:12];
         CAP_DL:     dl_ff     <= prod_ff[65:12];
         CAP_DH:     dh_ff     <= prod_ff[64:15];
         CAP_LIN:    lin_ff    <= sat32(prod_ff >>> 1);
         CAP_ANG_LO: ang_lo_ff <= prod_ff;
         CAP_ANG_HI: ang_ff    <= sat32(ang_full >>> 9);
         default: ;
      endcase
      if (cmd.load) begin
         rsp_ff <= '{x_position: pose_x_ff, y_position: pose_y_ff, heading: pose_h_ff,
                     linear_speed: lin_ff, angular_speed: ang_ff};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.capture_in),
      .heading (pose_h_ff),
      .cos_out (cos_v),
      .sin_out (sin_v),
      .done    (cordic_done)
   );

   odo_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_rem),
      .dividend  (dh_ff),
      .remainder (rem_v),
      .negative  (rem_neg),
      .done      (rem_done)
   );

   assign status.units_done = cordic_done && rem_done;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pose_needs_units: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_sel == MUL_X) |-> (cordic_done && rem_done))
      else $error("pose product issued before iterative units finished");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("result register not valid after load");

endmodule

FILE: sv/odo_ctrl.sv
module odo_ctrl
   import odo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic accept;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (accept) state_in = S_MUL_DR;
         S_MUL_DR:     state_in = S_MUL_DL;
         S_MUL_DL:     state_in = S_CAP_DL;
         S_CAP_DL:     state_in = S_MUL_DH;
         S_MUL_DH:     state_in = S_MUL_LIN;
         S_MUL_LIN:    state_in = S_MUL_ANG_LO;
         S_MUL_ANG_LO: state_in = S_MUL_ANG_HI;
         S_MUL_ANG_HI: state_in = S_CAP_ANG;
         S_CAP_ANG:    state_in = S_WAIT;
         S_WAIT:       if (status.units_done) state_in = S_MUL_X;
         S_MUL_X:      state_in = S_MUL_Y;
         S_MUL_Y:      state_in = S_CAP_Y;
         S_CAP_Y:      state_in = S_OUT;
         S_OUT:        if (status.out_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture_in = 1'b0;
      cmd.mul_sel    = MUL_NONE;
      cmd.cap        = CAP_NONE;
      cmd.start_rem  = 1'b0;
      cmd.load       = 1'b0;
      case (state_ff)
         S_IDLE:       cmd.capture_in = accept;
         S_MUL_DR:     cmd.mul_sel = MUL_DR;
         S_MUL_DL: begin
            cmd.mul_sel = MUL_DL;
            cmd.cap     = CAP_DR;
         end
         S_CAP_DL:     cmd.cap = CAP_DL;
         S_MUL_DH:     cmd.mul_sel = MUL_DH;
         S_MUL_LIN: begin
            cmd.mul_sel = MUL_LIN;
            cmd.cap     = CAP_DH;
         end
         S_MUL_ANG_LO: begin
            cmd.mul_sel   = MUL_ANG_LO;
            cmd.cap       = CAP_LIN;
            cmd.start_rem = 1'b1;
         end
         S_MUL_ANG_HI: begin
            cmd.mul_sel = MUL_ANG_HI;
            cmd.cap     = CAP_ANG_LO;
         end
         S_CAP_ANG:    cmd.cap = CAP_ANG_HI;
         S_MUL_X:      cmd.mul_sel = MUL_X;
         S_MUL_Y: begin
            cmd.mul_sel = MUL_Y;
            cmd.cap     = CAP_X;
         end
         S_CAP_Y:      cmd.cap = CAP_Y;
         S_OUT:        cmd.load = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_MUL_DR))
      else $error("accepted item did not start the sequence");

   a_out_returns_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && status.out_free) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after loading a result");

endmodule

FILE: sv/differential_drive_odometry.sv
// Differential-drive odometry engine.
// Input channel (req_*): one item holds the right and left encoder position
// counters. An item is taken when req_valid is high and req_stall is low.
// Result channel (rsp_*): one item per input, holding x, y, heading, linear
// speed and angular speed, presented from an output register.
// Configuration (csr_*): distance per count, inverse track width and sample
// rate, written with csr_write_enable while no item is in flight; the user
// must keep to this, as the block itself does not enforce it.
// The wait from acceptance to rsp_valid is set by the iterative CORDIC for
// the previous heading, and the remainder unit that wraps the heading change
// finishes well before it. req_stall stays high from acceptance until the
// result is loaded into the output register, so a new item is taken only
// once the result of the previous one has been loaded.
// When the receiver stalls, a finished result waits in the output register
// and the engine can take and work on the next item; that result is held
// back until the register is free.
// Reset (synchronous) clears the pose, the last counters and all handshake
// state, and loads the register defaults.
module differential_drive_odometry
   import odo_pkg::*;
#(
   parameter int COUNT_WIDTH  = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_write_enable,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [31:0]       csr_write_data
);

   cmd_type    cmd;
   status_type status;

   odo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   odo_dpath #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
